// ----- rtl/hsv_color_blend_defines.svh -----
// Assertion macros shared by the blend pipeline.
`ifndef HSV_COLOR_BLEND_DEFINES_SVH
`define HSV_COLOR_BLEND_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define HCB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define HCB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hcb_pkg.sv -----
package hcb_pkg;

  // Number of register stages from the input to the output register.
  localparam int unsigned NSTAGE = 9;

  // Hue sectors of sixty degrees each.
  typedef enum logic [2:0] {
    SECT_RY = 3'd0,
    SECT_YG = 3'd1,
    SECT_GC = 3'd2,
    SECT_CB = 3'd3,
    SECT_BM = 3'd4,
    SECT_MR = 3'd5
  } hcb_sector_t;

  // Per-color values that feed the two dividers.
  typedef struct packed {
    logic [7:0]  mx;
    logic [7:0]  d;
    logic [13:0] hnum;
    logic        hneg;
    logic [8:0]  hbase;
    logic [15:0] snum;
  } hcb_pre_t;

  // Data that rides alongside the divider stages.
  typedef struct packed {
    logic [7:0] mx_a;
    logic [7:0] mx_b;
    logic       hneg_a;
    logic       hneg_b;
    logic [8:0] hbase_a;
    logic [8:0] hbase_b;
    logic       gray_a;
    logic       gray_b;
    logic       black_a;
    logic       black_b;
    logic [8:0] w;
  } hcb_side_t;

  // Load enables for the two divider stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } hcb_div_en_t;

  // Exact floor(x / 255) for any 16-bit x below 65280.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = 17'(x) + 17'(x[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

  // Hue from the sector base and the signed sector offset, wrapped into 0..359.
  function automatic logic [8:0] hue_fix(input logic [8:0] base, input logic neg,
                                         input logic [7:0] q, input logic gray);
    logic signed [10:0] hs;
    if (gray) begin
      return 9'd0;
    end
    hs = $signed({2'b00, base}) + (neg ? -$signed({3'b000, q}) : $signed({3'b000, q}));
    if (hs < 0) begin
      hs = hs + 11'sd360;
    end
    return hs[8:0];
  endfunction

  // Signed product (xb - xa) * w for the linear blend.
  function automatic logic signed [18:0] mix_mul(input logic [8:0] xa, input logic [8:0] xb,
                                                 input logic [8:0] w);
    logic signed [9:0]  diff;
    logic signed [19:0] prod;
    diff = $signed({1'b0, xb}) - $signed({1'b0, xa});
    prod = diff * $signed({1'b0, w});
    return 19'(prod);
  endfunction

  // xa plus the product divided by 256, truncated toward zero.
  function automatic logic [8:0] mix_fin(input logic [8:0] xa, input logic signed [18:0] prod);
    logic signed [18:0] adj;
    logic signed [18:0] sh;
    adj = prod[18] ? (prod + 19'sd255) : prod;
    sh  = adj >>> 8;
    return 9'(xa + sh[8:0]);
  endfunction

  // Sector of a hue in 0..359.
  function automatic hcb_sector_t sect_of(input logic [8:0] h);
    if (h < 9'd60) begin
      return SECT_RY;
    end else if (h < 9'd120) begin
      return SECT_YG;
    end else if (h < 9'd180) begin
      return SECT_GC;
    end else if (h < 9'd240) begin
      return SECT_CB;
    end else if (h < 9'd300) begin
      return SECT_BM;
    end
    return SECT_MR;
  endfunction

  // Start angle of a sector.
  function automatic logic [8:0] sect_base(input hcb_sector_t s);
    case (s)
      SECT_RY: return 9'd0;
      SECT_YG: return 9'd60;
      SECT_GC: return 9'd120;
      SECT_CB: return 9'd180;
      SECT_BM: return 9'd240;
      default: return 9'd300;
    endcase
  endfunction

endpackage

// ----- rtl/hcb_rgb2hsv_prep.sv -----
module hcb_rgb2hsv_prep (
  input  logic [23:0]      color,
  output hcb_pkg::hcb_pre_t pre
);
  import hcb_pkg::*;

  logic [7:0]        r, g, b, mx, mn;
  logic signed [8:0] diff;
  logic [7:0]        mag;

  assign r = color[23:16];
  assign g = color[15:8];
  assign b = color[7:0];

  // Max and min of the three channels.
  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  // Pick the channel difference and base angle of the dominant channel.
  always_comb begin
    if (mx == r) begin
      diff      = $signed({1'b0, g}) - $signed({1'b0, b});
      pre.hbase = 9'd0;
    end else if (mx == g) begin
      diff      = $signed({1'b0, b}) - $signed({1'b0, r});
      pre.hbase = 9'd120;
    end else begin
      diff      = $signed({1'b0, r}) - $signed({1'b0, g});
      pre.hbase = 9'd240;
    end
    mag      = diff[8] ? 8'(-diff) : diff[7:0];
    pre.hneg = diff[8];
    pre.hnum = 14'(mag) * 14'd60;
    pre.mx   = mx;
    pre.d    = mx - mn;
    pre.snum = 16'(mx - mn) * 16'd255;
  end

endmodule

// ----- rtl/hcb_div.sv -----
module hcb_div (
  input  logic                 clk,
  input  hcb_pkg::hcb_div_en_t en,
  input  logic [15:0]          num,
  input  logic [7:0]           den,
  output logic [7:0]           q
);
  import hcb_pkg::*;

  logic [15:0] rem1_nxt, rem1_r, rem2;
  logic [7:0]  den1_r;
  logic [3:0]  qh_nxt, qh_r, ql_nxt;
  logic [7:0]  q_r;

  // Upper four quotient bits, restoring one bit at a time.
  always_comb begin
    rem1_nxt = num;
    for (int i = 7; i >= 4; i--) begin
      if (rem1_nxt >= (16'(den) << i)) begin
        rem1_nxt   = rem1_nxt - (16'(den) << i);
        qh_nxt[i-4] = 1'b1;
      end else begin
        qh_nxt[i-4] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      rem1_r <= rem1_nxt;
      den1_r <= den;
      qh_r   <= qh_nxt;
    end
  end

  // Lower four quotient bits.
  always_comb begin
    rem2 = rem1_r;
    for (int i = 3; i >= 0; i--) begin
      if (rem2 >= (16'(den1_r) << i)) begin
        rem2      = rem2 - (16'(den1_r) << i);
        ql_nxt[i] = 1'b1;
      end else begin
        ql_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      q_r <= {qh_r, ql_nxt};
    end
  end

  assign q = q_r;

endmodule

// ----- rtl/hsv_color_blend.sv -----
// HSV color blend, one pixel pair per clock while the output is not stalled.
// Input beat: color_a, color_b (red 23:16, green 15:8, blue 7:0) and blend,
// the weight of color_b in 256ths; values above 256 act as 256.
// Output beat: red, green and blue of the blend done in integer HSV space.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// Throughput is one beat per cycle while out_stall is low; the two-stage
// restoring dividers for hue and saturation set the depth, not the rate.
// Each stage holds its data until the next stage can take it, so bubbles
// are squeezed out when the receiver stalls; in_stall rises only once every
// stage is full and out_stall is high.
// A stall loses and repeats no beat.
// Reset clears all stage valid bits; no beat is in flight afterward.
`include "hsv_color_blend_defines.svh"

module hsv_color_blend (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_color_a,
  input  logic [23:0] in_color_b,
  input  logic [8:0]  in_blend,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);
  import hcb_pkg::*;

  logic [NSTAGE-1:0] vld_r, vld_nxt, rdy;

  // Ready chain: a stage loads when empty or when its successor loads.
  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    for (int k = 0; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTAGE-1];

  // Stage 0: max, min, divider operands.
  hcb_pre_t   pre_a, pre_b, pre_a_r, pre_b_r;
  logic [8:0] w_r;

  hcb_rgb2hsv_prep u_prep_a (.color(in_color_a), .pre(pre_a));
  hcb_rgb2hsv_prep u_prep_b (.color(in_color_b), .pre(pre_b));

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pre_a_r <= pre_a;
      pre_b_r <= pre_b;
      w_r     <= (in_blend > 9'd256) ? 9'd256 : in_blend;
    end
  end

  // Stages 1 and 2: hue and saturation dividers, side data alongside.
  hcb_div_en_t div_en;
  hcb_side_t   side_nxt, side1_r, side2_r;
  logic [7:0]  qh_a, qh_b, qs_a, qs_b;

  assign div_en.s1 = rdy[1];
  assign div_en.s2 = rdy[2];

  hcb_div u_div_ha (.clk(clk), .en(div_en), .num(16'(pre_a_r.hnum)), .den(pre_a_r.d),
                    .q(qh_a));
  hcb_div u_div_hb (.clk(clk), .en(div_en), .num(16'(pre_b_r.hnum)), .den(pre_b_r.d),
                    .q(qh_b));
  hcb_div u_div_sa (.clk(clk), .en(div_en), .num(pre_a_r.snum), .den(pre_a_r.mx),
                    .q(qs_a));
  hcb_div u_div_sb (.clk(clk), .en(div_en), .num(pre_b_r.snum), .den(pre_b_r.mx),
                    .q(qs_b));

  always_comb begin
    side_nxt.mx_a    = pre_a_r.mx;
    side_nxt.mx_b    = pre_b_r.mx;
    side_nxt.hneg_a  = pre_a_r.hneg;
    side_nxt.hneg_b  = pre_b_r.hneg;
    side_nxt.hbase_a = pre_a_r.hbase;
    side_nxt.hbase_b = pre_b_r.hbase;
    side_nxt.gray_a  = (pre_a_r.d == 8'd0);
    side_nxt.gray_b  = (pre_b_r.d == 8'd0);
    side_nxt.black_a = (pre_a_r.mx == 8'd0);
    side_nxt.black_b = (pre_b_r.mx == 8'd0);
    side_nxt.w       = w_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) side1_r <= side_nxt;
    if (rdy[2]) side2_r <= side1_r;
  end

  // Stage 3: finished HSV of both colors.
  logic [8:0] ha_r, hb_r, sa_r, sb_r, va_r, vb_r, w3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      ha_r <= hue_fix(side2_r.hbase_a, side2_r.hneg_a, qh_a, side2_r.gray_a);
      hb_r <= hue_fix(side2_r.hbase_b, side2_r.hneg_b, qh_b, side2_r.gray_b);
      sa_r <= side2_r.black_a ? 9'd0 : 9'(qs_a);
      sb_r <= side2_r.black_b ? 9'd0 : 9'(qs_b);
      va_r <= 9'(side2_r.mx_a);
      vb_r <= 9'(side2_r.mx_b);
      w3_r <= side2_r.w;
    end
  end

  // Stage 4: blend products.
  logic signed [18:0] ph_r, ps_r, pv_r;
  logic [8:0]         ha4_r, sa4_r, va4_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      ph_r  <= mix_mul(ha_r, hb_r, w3_r);
      ps_r  <= mix_mul(sa_r, sb_r, w3_r);
      pv_r  <= mix_mul(va_r, vb_r, w3_r);
      ha4_r <= ha_r;
      sa4_r <= sa_r;
      va4_r <= va_r;
    end
  end

  // Stage 5: blended HSV, sector and scaled sector remainder.
  logic [8:0]  h5, hmod5;
  logic [9:0]  rem17;
  hcb_sector_t sec5;
  hcb_sector_t sec5_r, sec6_r, sec7_r;
  logic [7:0]  rem5_r, s5_r, v5_r;

  always_comb begin
    h5    = mix_fin(ha4_r, ph_r);
    sec5  = sect_of(h5);
    hmod5 = h5 - sect_base(sec5);
    rem17 = 10'(hmod5) * 10'd17;
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sec5_r <= sec5;
      rem5_r <= 8'(rem17 >> 2);
      s5_r   <= 8'(mix_fin(sa4_r, ps_r));
      v5_r   <= 8'(mix_fin(va4_r, pv_r));
    end
  end

  // Stage 6: first products of the sector formula.
  logic [15:0] pp6_r, sr6_r, st6_r;
  logic [7:0]  v6_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      pp6_r  <= 16'(v5_r) * 16'(8'd255 - s5_r);
      sr6_r  <= 16'(s5_r) * 16'(rem5_r);
      st6_r  <= 16'(s5_r) * 16'(8'd255 - rem5_r);
      v6_r   <= v5_r;
      sec6_r <= sec5_r;
    end
  end

  // Stage 7: p, and the products behind q and t.
  logic [7:0]  p7_r, v7_r;
  logic [15:0] qf7_r, tf7_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      p7_r   <= div255(pp6_r);
      qf7_r  <= 16'(v6_r) * 16'(8'd255 - div255(sr6_r));
      tf7_r  <= 16'(v6_r) * 16'(8'd255 - div255(st6_r));
      v7_r   <= v6_r;
      sec7_r <= sec6_r;
    end
  end

  // Stage 8: output register, channels picked by sector.
  logic [7:0] q8, t8, red_r, green_r, blue_r;

  assign q8 = div255(qf7_r);
  assign t8 = div255(tf7_r);

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      case (sec7_r)
        SECT_RY: begin red_r <= v7_r; green_r <= t8;   blue_r <= p7_r; end
        SECT_YG: begin red_r <= q8;   green_r <= v7_r; blue_r <= p7_r; end
        SECT_GC: begin red_r <= p7_r; green_r <= v7_r; blue_r <= t8;   end
        SECT_CB: begin red_r <= p7_r; green_r <= q8;   blue_r <= v7_r; end
        SECT_BM: begin red_r <= t8;   green_r <= p7_r; blue_r <= v7_r; end
        default: begin red_r <= v7_r; green_r <= p7_r; blue_r <= q8;   end
      endcase
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // The input only stalls when the whole pipe is full behind a stalled output.
  `HCB_ASSERT_IMP(a_stall_origin, in_stall, out_valid && out_stall && (&vld_r),
                  "input stalled while the pipeline has room")
  // An accepted beat always lands in the first stage.
  `HCB_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, vld_r[0],
                   "accepted beat missing from the first stage")
  // A full stage that cannot move keeps its valid bit.
  `HCB_ASSERT_NEXT(a_hold_mid, vld_r[4] && !rdy[5], vld_r[4],
                   "stage dropped a beat while blocked")

endmodule
